FILE: hdl/pli_pkg.sv
// pli_pkg: shared types and constants for the piecewise linear interpolator.
// Request/result structs, register codes, region codes and sequencer states.
// No dependencies.
package pli_pkg;

  localparam int VALUE_W   = 32;
  localparam int PIDX_W    = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRAP_MODE = 1'b1;

  localparam logic [CNT_W-1:0] MIN_POINTS = 7'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] RGN_INSIDE = 2'd0;
  localparam logic [1:0] RGN_FRONT  = 2'd1;
  localparam logic [1:0] RGN_BACK   = 2'd2;

  typedef struct packed {
    logic                      mode;
    logic [PIDX_W-1:0]         point_index;
    logic signed [VALUE_W-1:0] x_value;
    logic signed [VALUE_W-1:0] y_value;
  } pli_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] y_result;
    logic [1:0]                region;
  } pli_out_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] x;
    logic signed [VALUE_W-1:0] y;
  } pli_point_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDN,
    ST_CHK,
    ST_LDA,
    ST_LDB,
    ST_SCAN,
    ST_PREP,
    ST_MAG,
    ST_MUL,
    ST_DCHK,
    ST_DIV,
    ST_SAT,
    ST_FIN
  } pli_state_t;

endpackage

FILE: hdl/piecewise_linear_interpolator.sv
// piecewise_linear_interpolator: breakpoint table, segment search and line evaluation.
// Uses pli_pkg (types, codes, sequencer states).
//
//   channel | ports                                  | request moved when
//   --------+----------------------------------------+--------------------------------
//   input   | start, busy, in_payload                | start high and busy low
//   result  | out_valid, out_payload                 | out_valid high (one cycle)
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_wdata | cfg_valid and cfg_ready high
//
// Load request: the point is written when the request is taken, busy stays low.
// Query request: the first and last points are read; lines through the two end points of
// one side read one more point, and inside the table one table entry is read per cycle
// on the single read port up to the segment end point. Then the 32-step restoring
// divider runs on the magnitudes, and the quotient is saturated and added. Quotient
// overflow skips the divider.
// Reset is synchronous, active low; the table is not cleared. Results cannot be stalled.
module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  pli_pkg::pli_in_t                   in_payload,
  output logic                               out_valid,
  output pli_pkg::pli_out_t                  out_payload,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pli_pkg::CNT_W-1:0]          cfg_wdata
);
  import pli_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW  = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int VW  = VALUE_W;
  localparam int DCW = $clog2(VW + 1);

  localparam logic [VW-1:0] HALF_U = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VMAX_U = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW:0]   QUO_MIN = {2'b11, {(VW-1){1'b0}}};
  localparam logic [VW:0]   QUO_MAX = {2'b00, {(VW-1){1'b1}}};

  pli_state_t state_r, state_nxt;

  logic [CNT_W-1:0] pcount_r;
  logic             xmode_r;

  pli_point_t mem [TABLE_DEPTH];
  pli_point_t rd_q_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;

  logic [NW-1:0] n_w, n_eff;
  logic [AW-1:0] last_idx, prev_idx;

  logic [VW-1:0]   q_r, q_nxt;
  pli_point_t      a_r, a_nxt, b_r, b_nxt;
  logic [AW-1:0]   scan_i_r, scan_i_nxt;
  logic [1:0]      region_r, region_nxt;
  logic [VW:0]     dy_r, dy_nxt, dx_r, dx_nxt, dq_r, dq_nxt;
  logic [VW-1:0]   my_r, my_nxt, mx_r, mx_nxt, mq_r, mq_nxt;
  logic            neg_r, neg_nxt;
  logic [2*VW-1:0] prod_r, prod_nxt;
  logic            ovf_r, ovf_nxt;
  logic [VW-1:0]   rem_r, rem_nxt, dlo_r, dlo_nxt;
  logic [DCW-1:0]  cnt_r, cnt_nxt;
  logic [VW:0]     quo_r, quo_nxt;
  logic            out_valid_r, out_valid_nxt;
  pli_out_t        out_payload_r, out_payload_nxt;

  logic [VW:0]   shifted, sub;
  logic [VW+1:0] sum;

  assign busy        = (state_r != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  always_comb begin
    n_w = NW'(pcount_r);
    if (n_w < NW'(MIN_POINTS)) begin
      n_eff = NW'(MIN_POINTS);
    end else if (n_w > NW'(TABLE_DEPTH)) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = n_w;
    end
    last_idx = AW'(n_eff - NW'(1));
    prev_idx = AW'(n_eff - NW'(2));
  end

  assign we = start && !busy && (in_payload.mode == MODE_LOAD) &&
              (NW'(in_payload.point_index) < NW'(TABLE_DEPTH));
  assign waddr = AW'(in_payload.point_index);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= '{x: in_payload.x_value, y: in_payload.y_value};
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    rd_addr         = '0;
    q_nxt           = q_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    scan_i_nxt      = scan_i_r;
    region_nxt      = region_r;
    dy_nxt          = dy_r;
    dx_nxt          = dx_r;
    dq_nxt          = dq_r;
    my_nxt          = my_r;
    mx_nxt          = mx_r;
    mq_nxt          = mq_r;
    neg_nxt         = neg_r;
    prod_nxt        = prod_r;
    ovf_nxt         = ovf_r;
    rem_nxt         = rem_r;
    dlo_nxt         = dlo_r;
    cnt_nxt         = cnt_r;
    quo_nxt         = quo_r;
    out_valid_nxt   = 1'b0;
    out_payload_nxt = out_payload_r;
    shifted         = {rem_r, dlo_r[VW-1]};
    sub             = shifted - {1'b0, mx_r};
    sum             = {{2{a_r.y[VW-1]}}, a_r.y} + {quo_r[VW], quo_r};
    case (state_r)
      ST_IDLE: begin
        if (start && in_payload.mode == MODE_QUERY) begin
          q_nxt     = in_payload.x_value;
          state_nxt = ST_RDN;
        end
      end
      ST_RDN: begin
        rd_addr   = last_idx;
        a_nxt     = rd_q_r;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        b_nxt = rd_q_r;
        if ($signed(q_r) < $signed(a_r.x)) begin
          region_nxt = RGN_FRONT;
          rd_addr    = AW'(1);
          state_nxt  = xmode_r ? ST_LDB : ST_PREP;
        end else if ($signed(q_r) > $signed(rd_q_r.x)) begin
          region_nxt = RGN_BACK;
          rd_addr    = prev_idx;
          state_nxt  = xmode_r ? ST_LDA : ST_PREP;
        end else begin
          region_nxt = RGN_INSIDE;
          rd_addr    = AW'(1);
          scan_i_nxt = AW'(1);
          state_nxt  = ST_SCAN;
        end
      end
      ST_LDA: begin
        a_nxt     = rd_q_r;
        state_nxt = ST_PREP;
      end
      ST_LDB: begin
        b_nxt     = rd_q_r;
        state_nxt = ST_PREP;
      end
      ST_SCAN: begin
        rd_addr = scan_i_r + AW'(1);
        if ($signed(rd_q_r.x) > $signed(q_r)) begin
          b_nxt     = rd_q_r;
          state_nxt = ST_PREP;
        end else if (scan_i_r == last_idx) begin
          // no greater x: return the last y
          a_nxt     = rd_q_r;
          quo_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          a_nxt      = rd_q_r;
          scan_i_nxt = scan_i_r + AW'(1);
        end
      end
      ST_PREP: begin
        dy_nxt    = {b_r.y[VW-1], b_r.y} - {a_r.y[VW-1], a_r.y};
        dx_nxt    = {b_r.x[VW-1], b_r.x} - {a_r.x[VW-1], a_r.x};
        dq_nxt    = {q_r[VW-1], q_r} - {a_r.x[VW-1], a_r.x};
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        my_nxt    = dy_r[VW] ? VW'(-dy_r) : VW'(dy_r);
        mx_nxt    = dx_r[VW] ? VW'(-dx_r) : VW'(dx_r);
        mq_nxt    = dq_r[VW] ? VW'(-dq_r) : VW'(dq_r);
        neg_nxt   = dy_r[VW] ^ dx_r[VW] ^ dq_r[VW];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt = my_r * mq_r;
        if (mx_r == '0) begin
          quo_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DCHK;
        end
      end
      ST_DCHK: begin
        ovf_nxt   = (prod_r[2*VW-1:VW] >= mx_r);
        rem_nxt   = prod_r[2*VW-1:VW];
        dlo_nxt   = prod_r[VW-1:0];
        cnt_nxt   = '0;
        state_nxt = (prod_r[2*VW-1:VW] >= mx_r) ? ST_SAT : ST_DIV;
      end
      ST_DIV: begin
        if (shifted >= {1'b0, mx_r}) begin
          rem_nxt = sub[VW-1:0];
          dlo_nxt = {dlo_r[VW-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[VW-1:0];
          dlo_nxt = {dlo_r[VW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + DCW'(1);
        if (cnt_r == DCW'(VW - 1)) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (neg_r) begin
          quo_nxt = (ovf_r || dlo_r > HALF_U) ? QUO_MIN : -{1'b0, dlo_r};
        end else begin
          quo_nxt = (ovf_r || dlo_r > VMAX_U) ? QUO_MAX : {1'b0, dlo_r};
        end
        state_nxt = ST_SAT == state_r ? ST_FIN : state_r;
      end
      ST_FIN: begin
        if (sum[VW+1] != sum[VW-1] || sum[VW] != sum[VW-1]) begin
          out_payload_nxt.y_result = sum[VW+1] ? ~VMAX_U : VMAX_U;
        end else begin
          out_payload_nxt.y_result = sum[VW-1:0];
        end
        out_payload_nxt.region = region_r;
        out_valid_nxt          = 1'b1;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pcount_r    <= MIN_POINTS;
      xmode_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POINT_COUNT: pcount_r <= cfg_wdata;
          REG_EXTRAP_MODE: xmode_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r           <= q_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    scan_i_r      <= scan_i_nxt;
    region_r      <= region_nxt;
    dy_r          <= dy_nxt;
    dx_r          <= dx_nxt;
    dq_r          <= dq_nxt;
    my_r          <= my_nxt;
    mx_r          <= mx_nxt;
    mq_r          <= mq_nxt;
    neg_r         <= neg_nxt;
    prod_r        <= prod_nxt;
    ovf_r         <= ovf_nxt;
    rem_r         <= rem_nxt;
    dlo_r         <= dlo_nxt;
    cnt_r         <= cnt_nxt;
    quo_r         <= quo_nxt;
    out_payload_r <= out_payload_nxt;
  end

  a_strobe_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FIN))
    else $error("result strobe without a finished query");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_payload.mode == MODE_QUERY) |=> busy)
    else $error("query request did not start the sequencer");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_payload.mode == MODE_LOAD) |=> (!busy && !out_valid))
    else $error("load request disturbed the sequencer");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_i_r <= last_idx))
    else $error("segment search ran past the last breakpoint");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.region == RGN_INSIDE || out_payload.region == RGN_FRONT ||
                   out_payload.region == RGN_BACK))
    else $error("bad region code on result");

endmodule

FILE: sim/pli_checker.sv
// pli_checker: watches the request, result and register channels of the interpolator,
// keeps its own breakpoint table and predicts every query result in order.
// Depends on pli_pkg for the payload types and the register and region codes.
module pli_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  pli_pkg::pli_in_t              in_payload,
  input  logic                          out_valid,
  input  pli_pkg::pli_out_t             out_payload,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pli_pkg::CNT_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            pending,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam int     DEPTH   = 64;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;

  logic signed [VALUE_W-1:0] bp_x [DEPTH];
  logic signed [VALUE_W-1:0] bp_y [DEPTH];
  logic [CNT_W-1:0]          point_count  = MIN_POINTS;
  logic                      extrap_pairs = 1'b0;
  pli_out_t                  expected_results [$];
  int                        bad  = 0;
  int                        seen = 0;

  // y0 + dy*(q-x0)/dx, quotient truncated toward zero, quotient and sum saturated
  function automatic logic signed [VALUE_W-1:0] line_value(
    input logic signed [VALUE_W-1:0] x0, y0, x1, y1, q);
    longint    dy, dx, dq, quo, sum;
    bit [63:0] my, mx, mq, mag;
    bit        neg;
    dy = longint'(y1) - longint'(y0);
    dx = longint'(x1) - longint'(x0);
    dq = longint'(q) - longint'(x0);
    if (dx == 0) return y0;
    my  = (dy < 0) ? -dy : dy;
    mx  = (dx < 0) ? -dx : dx;
    mq  = (dq < 0) ? -dq : dq;
    mag = (my * mq) / mx;
    neg = (dy < 0) ^ (dx < 0) ^ (dq < 0);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      quo = -longint'(mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      quo = longint'(mag);
    end
    sum = longint'(y0) + quo;
    if (sum > VAL_MAX) sum = VAL_MAX;
    if (sum < VAL_MIN) sum = VAL_MIN;
    return sum[VALUE_W-1:0];
  endfunction

  function automatic pli_out_t interpolate(input logic signed [VALUE_W-1:0] q);
    int       n;
    bit       found;
    pli_out_t r;
    n = point_count;
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > DEPTH) n = DEPTH;
    if (q < bp_x[0]) begin
      r.region = RGN_FRONT;
      if (extrap_pairs)
        r.y_result = line_value(bp_x[0], bp_y[0], bp_x[1], bp_y[1], q);
      else
        r.y_result = line_value(bp_x[0], bp_y[0], bp_x[n-1], bp_y[n-1], q);
    end else if (q > bp_x[n-1]) begin
      r.region = RGN_BACK;
      if (extrap_pairs)
        r.y_result = line_value(bp_x[n-2], bp_y[n-2], bp_x[n-1], bp_y[n-1], q);
      else
        r.y_result = line_value(bp_x[0], bp_y[0], bp_x[n-1], bp_y[n-1], q);
    end else begin
      r.region   = RGN_INSIDE;
      r.y_result = bp_y[n-1];
      found      = 1'b0;
      for (int i = 1; i < n; i++) begin
        if (!found && bp_x[i] > q) begin
          r.y_result = line_value(bp_x[i-1], bp_y[i-1], bp_x[i], bp_y[i], q);
          found      = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pli_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POINT_COUNT) point_count = cfg_wdata;
        else extrap_pairs = cfg_wdata[0];
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("[%0t] unexpected result: y_result %0d region %0d", $realtime,
                     out_payload.y_result, out_payload.region);
        end else begin
          want = expected_results.pop_front();
          seen++;
          if (out_payload.y_result !== want.y_result || out_payload.region !== want.region)
          begin
            bad++;
            if (bad <= 10)
              $display("[%0t] mismatch: y_result exp %0d got %0d, region exp %0d got %0d",
                       $realtime, want.y_result, out_payload.y_result, want.region,
                       out_payload.region);
          end
        end
      end
      if (start && !busy) begin
        if (in_payload.mode == MODE_LOAD) begin
          bp_x[in_payload.point_index] = in_payload.x_value;
          bp_y[in_payload.point_index] = in_payload.y_value;
        end else begin
          expected_results.insert(expected_results.size(), interpolate(in_payload.x_value));
        end
      end
    end
    mismatches <= bad;
    pending    <= expected_results.size();
    checked    <= seen;
  end

endmodule

FILE: sim/piecewise_linear_interpolator_tb.sv
// piecewise_linear_interpolator_tb: drives breakpoint loads, queries and register writes
// into the interpolator and gives the verdict from the counts of pli_checker.
// Depends on pli_pkg, pli_checker and the piecewise_linear_interpolator RTL.
module piecewise_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int ITEM_TARGET   = 1000;
  localparam int SETTLE_CYCLES = 120;
  localparam int DEPTH         = 64;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  // first register settings: counts and line modes, entry 0 first
  localparam logic [7:0][CNT_W-1:0] PRESET_COUNTS =
    {7'd5, 7'd65, 7'd2, 7'd127, 7'd0, 7'd64, 7'd64, 7'd3};
  localparam logic [7:0] PRESET_PAIRS = 8'b0011_0101;

  typedef enum int {
    SHAPE_SORTED, SHAPE_WIDE, SHAPE_STEEP, SHAPE_DUPLICATE, SHAPE_SCRAMBLED
  } shape_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  pli_in_t              in_payload = '0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CNT_W-1:0]     cfg_wdata  = '0;
  logic                 busy;
  logic                 out_valid;
  pli_out_t             out_payload;
  logic                 cfg_ready;
  int                   mismatches;
  int                   pending;
  int                   checked;

  int  cycles   = 0;
  int  requests = 0;
  int  queries  = 0;
  int  settings = 0;
  bit  gaps_on  = 1'b1;
  logic signed [VALUE_W-1:0] tx [DEPTH];
  logic signed [VALUE_W-1:0] ty [DEPTH];

  piecewise_linear_interpolator dut (
    .clk, .rst_n, .start, .busy, .in_payload, .out_valid, .out_payload,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  pli_checker monitor (
    .clk, .rst_n, .start, .busy, .in_payload, .out_valid, .out_payload,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata, .mismatches, .pending, .checked
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_request(input pli_in_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_payload <= req;
    do @(posedge clk); while (busy);
    requests++;
  endtask

  task automatic load_point(input int idx, input logic signed [VALUE_W-1:0] x, y);
    pli_in_t req;
    req.mode        = MODE_LOAD;
    req.point_index = idx[PIDX_W-1:0];
    req.x_value     = x;
    req.y_value     = y;
    tx[idx] = x;
    ty[idx] = y;
    drive_request(req);
  endtask

  task automatic query(input logic signed [VALUE_W-1:0] x);
    pli_in_t req;
    req.mode        = MODE_QUERY;
    req.point_index = PIDX_W'($urandom_range(0, DEPTH - 1));
    req.x_value     = x;
    req.y_value     = $urandom();
    queries++;
    drive_request(req);
  endtask

  // stop requesting, let every result come back and the block go quiet
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] count, input logic pairs);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_wdata <= count;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_EXTRAP_MODE;
    cfg_wdata <= {{(CNT_W-1){1'b0}}, pairs};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic build_table(input int n, input shape_t shape);
    logic signed [VALUE_W-1:0] nx [DEPTH];
    logic signed [VALUE_W-1:0] ny [DEPTH];
    longint cur, step;
    bit     descending;
    cur = longint'($signed($urandom())) >>> 4;
    for (int i = 0; i < n; i++) begin
      step = 0;
      ny[i] = $signed($urandom()) >>> $urandom_range(0, 16);
      case (shape)
        SHAPE_SORTED:    step = $urandom_range(1, 1 << 20);
        SHAPE_WIDE: begin
          cur   = longint'(VAL_MIN) + (longint'(i) * 64'sd4294967295) / (n - 1);
          ny[i] = $urandom();
        end
        SHAPE_STEEP: begin
          step  = $urandom_range(1, 4);
          ny[i] = $urandom();
        end
        SHAPE_DUPLICATE: step = $urandom_range(0, 1) ? 0 : $urandom_range(1, 1 << 18);
        default:         cur  = longint'($signed($urandom()));
      endcase
      nx[i] = cur[VALUE_W-1:0];
      cur   = cur + step;
    end
    descending = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (descending) load_point(n - 1 - i, nx[n-1-i], ny[n-1-i]);
      else load_point(i, nx[i], ny[i]);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_query_x(input int n);
    longint lo, hi, v;
    int     i;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: v = tx[i];
      1: v = longint'(tx[i]) + longint'($urandom_range(0, 6)) - 3;
      2, 3: begin
        if (i == n - 1) i = n - 2;
        lo = tx[i];
        hi = tx[i+1];
        v  = (hi > lo) ? lo + longint'($urandom()) % (hi - lo) : lo;
      end
      4: v = longint'(tx[0]) - longint'($urandom_range(1, 1 << 16));
      5: v = longint'(tx[n-1]) + longint'($urandom_range(1, 1 << 16));
      6: v = $urandom_range(0, 1) ? longint'(VAL_MIN) : longint'(VAL_MAX);
      default: v = longint'($signed($urandom()));
    endcase
    return v[VALUE_W-1:0];
  endfunction

  initial begin
    logic [CNT_W-1:0] count;
    logic             pairs;
    shape_t           shape;
    int               used, n_req, idx, r, phase;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: three points, one line through first and last
    load_point(0, -32'sd262144, 32'sd65536);
    load_point(1, 32'sd0, 32'sd196608);
    load_point(2, 32'sd262144, -32'sd131072);
    query(VAL_MIN);
    query(-32'sd262145);
    query(-32'sd262144);
    query(-32'sd131072);
    query(32'sd0);
    query(32'sd131072);
    query(32'sd262144);
    query(32'sd262145);
    query(VAL_MAX);
    // steep line: quotient and sum saturate
    load_point(2, -32'sd262143, VAL_MAX);
    query(VAL_MAX);
    load_point(0, -32'sd262144, VAL_MIN + 32'sd5);
    query(VAL_MIN);
    // all x equal: zero-width lines return the base y
    load_point(1, -32'sd262144, 32'sd0);
    load_point(2, -32'sd262144, 32'sd7);
    query(32'sd5);
    query(-32'sd300000);
    query(-32'sd262144);

    phase = 0;
    while (requests < ITEM_TARGET) begin
      if (phase < 8) begin
        count = PRESET_COUNTS[phase];
        pairs = PRESET_PAIRS[phase];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) count = CNT_W'($urandom_range(3, 10));
        else if (r < 85) count = CNT_W'($urandom_range(11, 64));
        else if (r < 93) count = CNT_W'($urandom_range(0, 2));
        else count = CNT_W'($urandom_range(65, 127));
        pairs = 1'($urandom_range(0, 1));
      end
      configure(count, pairs);
      used = (count < MIN_POINTS) ? MIN_POINTS : (count > DEPTH) ? DEPTH : count;
      gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 40) shape = SHAPE_SORTED;
      else if (r < 55) shape = SHAPE_WIDE;
      else if (r < 70) shape = SHAPE_STEEP;
      else if (r < 85) shape = SHAPE_DUPLICATE;
      else shape = SHAPE_SCRAMBLED;
      build_table(used, shape);
      n_req = (used > 16) ? $urandom_range(25, 45) : $urandom_range(30, 70);
      repeat (n_req) begin
        if ($urandom_range(0, 99) < 8) begin
          idx = $urandom_range(0, DEPTH - 1);
          if (shape != SHAPE_SCRAMBLED && idx < used) load_point(idx, tx[idx], $urandom());
          else load_point(idx, $urandom(), $urandom());
        end else begin
          query(pick_query_x(used));
        end
      end
      phase++;
    end

    drain();
    $display("Covered %0d requests (%0d queries, %0d loads) over %0d register settings.",
             requests, queries, requests - queries, settings);
    $display("%0d results compared, %0d mismatches, %0d still outstanding.",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
